// ===== rtl/core/pwq_pkg.sv =====
// ============================================================================
// pwq_pkg - shared types and constants of the priority wait queue
// Sizes of the queue, the operation and status codes, and the structs that
// travel between the cells of the sorted row.
// ============================================================================
package pwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int THREAD_W    = 6;
  localparam int PRIO_W      = 8;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // One queue entry.
  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [PRIO_W-1:0]   prio;
  } slot_t;

  // Command broadcast to every cell for the word being applied.
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [THREAD_W-1:0] tid;
    logic [PRIO_W-1:0]   prio;
  } cmd_t;

  // What a cell hands to its right-hand neighbour.
  typedef struct packed {
    slot_t slot;   // current contents, shifted right on insert
    logic  stay;   // this entry sorts ahead of the new thread
    logic  found;  // the removed thread sits here or further left
  } link_t;

endpackage

// ===== rtl/core/pwq_cell.sv =====
// ============================================================================
// pwq_cell - one position of the sorted queue row
// Holds one entry; on insert it keeps, takes the new thread or takes the
// left neighbour's entry, and on remove it takes the right neighbour's entry.
// ============================================================================
module pwq_cell (
  input  logic           clk,
  input  pwq_pkg::cmd_t  cmd,
  input  logic           valid,
  input  pwq_pkg::link_t left,
  input  pwq_pkg::slot_t right,
  output pwq_pkg::link_t link_out,
  output pwq_pkg::slot_t slot
);
  import pwq_pkg::*;

  slot_t slot_next;

  always_comb begin
    link_out.slot  = slot;
    link_out.stay  = valid && (slot.prio <= cmd.prio);
    link_out.found = left.found || (valid && (slot.thread == cmd.tid));
  end

  always_comb begin
    slot_next = slot;
    if (cmd.ins && !link_out.stay) begin
      if (left.stay) begin
        slot_next.thread = cmd.tid;
        slot_next.prio   = cmd.prio;
      end else begin
        slot_next = left.slot;
      end
    end else if (cmd.rem && link_out.found) begin
      slot_next = right;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

// ===== rtl/core/priority_wait_queue_unit.sv =====
// ============================================================================
// priority_wait_queue_unit - sorted wait queue of one event
// A row of cells keeps waiting threads ordered by priority, oldest first
// among equals, and answers each word with the head of the queue.
// ============================================================================
// Usage:
//   Input words arrive on s_tvalid/s_tready. s_tuser carries the operation
//   (insert, remove, query; the unused code acts as a query) and s_tdata the
//   thread identifier and the priority of an inserted thread.
//   Each input word produces exactly one output word on m_tvalid/m_tready.
//   m_tuser carries the status (done, queue full, thread not found) and the
//   empty flag; m_tdata carries the head thread and its priority, both zero
//   when the queue is empty.
//   The whole row of cells updates in the cycle the word is accepted, so the
//   result is offered in the next cycle. The output register is the only place
//   a result waits, and a new word is taken only once it has been collected. A
//   stall on the output simply holds s_tready low; nothing is lost.
//   Reset empties the queue at once by clearing the occupancy count; the
//   entries themselves are not cleared, as only occupied ones are ever read.
//   A remove deletes the first matching thread and closes the gap; a remove
//   of an absent thread or an insert into a full queue changes nothing and
//   is flagged in the status.
// ============================================================================
module priority_wait_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] operation
  input  logic [15:0] s_tdata,   // [5:0] thread_id, [13:6] priority_req, [15:14] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // [1:0] status, [2] queue_empty
  output logic [15:0] m_tdata    // [5:0] head_thread, [13:6] head_priority, [15:14] zero
);
  import pwq_pkg::*;

  logic               accept;
  logic               is_full;
  logic               found_any;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  status_t            status;
  status_t            status_next;
  logic               out_valid;
  cmd_t               cmd;
  logic               cell_valid [QUEUE_DEPTH];
  link_t              link       [QUEUE_DEPTH+1];
  slot_t              cell_slot  [QUEUE_DEPTH];

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !out_valid;
  assign is_full  = (count == COUNT_W'(QUEUE_DEPTH));

  // The command reaches the cells only for the cycle of acceptance.
  always_comb begin
    cmd.tid  = s_tdata[THREAD_W-1:0];
    cmd.prio = s_tdata[THREAD_W+PRIO_W-1:THREAD_W];
    cmd.ins  = accept && (s_tuser == OP_INSERT) && !is_full;
    cmd.rem  = accept && (s_tuser == OP_REMOVE);
  end

  // Left edge of the row: everything sorts after it and nothing is found yet.
  assign link[0] = '{slot: '0, stay: 1'b1, found: 1'b0};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t right_slot;

    assign cell_valid[i] = (COUNT_W'(i) < count);

    if (i == QUEUE_DEPTH - 1) begin : g_last
      // Nothing lies beyond the last cell; it keeps its own entry on remove.
      assign right_slot = cell_slot[i];
    end else begin : g_mid
      assign right_slot = cell_slot[i+1];
    end

    pwq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .valid    (cell_valid[i]),
      .left     (link[i]),
      .right    (right_slot),
      .link_out (link[i+1]),
      .slot     (cell_slot[i])
    );
  end

  // The found chain leaves the right-hand end with the overall match result.
  assign found_any = link[QUEUE_DEPTH].found;

  always_comb begin
    count_next  = count;
    status_next = status;
    if (accept) begin
      status_next = ST_DONE;
      if (s_tuser == OP_INSERT) begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end else if (s_tuser == OP_REMOVE) begin
        if (found_any) begin
          count_next = count - 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      status    <= ST_DONE;
    end else begin
      count  <= count_next;
      status <= status_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The row cannot change while a result waits, so the head is read directly.
  always_comb begin
    m_tvalid   = out_valid;
    m_tuser[1:0] = status;
    m_tuser[2] = (count == '0);
    m_tdata    = '0;
    if (count != '0) begin
      m_tdata[THREAD_W-1:0]                 = cell_slot[0].thread;
      m_tdata[THREAD_W+PRIO_W-1:THREAD_W]   = cell_slot[0].prio;
    end
  end

endmodule

// ===== rtl/core/pwq_checker.sv =====
// ============================================================================
// pwq_checker - port-level checks of the priority wait queue
// Watches the stream ports over time and reports violations.
// ============================================================================
module pwq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [2:0]  m_tuser,
  input logic [15:0] m_tdata
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word withdrawn while stalled");

  // Every accepted word yields a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

  // No new word is taken while a result still waits.
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted while a result waits");

  // An empty queue reports a zero head.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> (m_tdata == 16'd0))
    else $error("empty queue reported a head thread");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind priority_wait_queue_unit pwq_checker u_pwq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

// ===== verif/priority_wait_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// priority_wait_queue_unit_tb - self-checking bench for the sorted wait queue
// Streams insert, remove and query words into the unit, keeps its own sorted
// list of waiting threads and checks every returned head report against it.
// ----------------------------------------------------------------------------
module priority_wait_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwq_pkg::*;

  // The fourth operation code has no name in the package; the unit treats it
  // as a query.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         RANDOM_WORDS = 450;

  // One word waiting to be offered, or a marker that makes the sender pause
  // until every outstanding head report has come back.
  typedef struct packed {
    logic                drain;
    logic [1:0]          op;
    logic [THREAD_W-1:0] tid;
    logic [PRIO_W-1:0]   prio;
  } request_t;

  // What the unit should answer for one accepted word.
  typedef struct packed {
    status_t             status;
    logic                empty;
    logic [THREAD_W-1:0] thread;
    logic [PRIO_W-1:0]   prio;
  } head_report_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_e;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser  = 2'd0;   // [1:0] operation
  logic [15:0] s_tdata  = 16'd0;  // [5:0] thread_id, [13:6] priority_req, [15:14] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [2:0]  m_tuser;           // [1:0] status, [2] queue_empty
  logic [15:0] m_tdata;           // [5:0] head_thread, [13:6] head_priority, [15:14] zero

  request_t     words_to_send[$];
  head_report_t head_reports_due[$];
  slot_t        waiting_threads[$];   // the predicted queue, head first
  logic [THREAD_W-1:0] planned_ids[$]; // threads the stimulus expects to be waiting

  logic     took_word = 1'b0;
  int       error_count = 0;
  int       reports_checked = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  bit       long_hold_done = 1'b0;
  rx_mode_e rx_mode = RX_OPEN;
  int       mode_left = 0;

  priority_wait_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Applies one accepted word to the predicted queue and returns the report
  // the unit should give for it. An insert goes in front of the first entry
  // with a strictly larger priority number, so equal priorities stay in
  // arrival order; a remove takes out only the first matching thread.
  function automatic head_report_t apply_to_wait_list(request_t req);
    head_report_t rep;
    slot_t        entry;
    int           pos;
    rep = '0;
    rep.status = ST_DONE;
    pos = 0;
    if (req.op == OP_INSERT) begin
      if (waiting_threads.size() >= QUEUE_DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        while (pos < waiting_threads.size() && waiting_threads[pos].prio <= req.prio) pos++;
        entry.thread = req.tid;
        entry.prio   = req.prio;
        waiting_threads.insert(pos, entry);
      end
    end else if (req.op == OP_REMOVE) begin
      while (pos < waiting_threads.size() && waiting_threads[pos].thread != req.tid) pos++;
      if (pos >= waiting_threads.size()) rep.status = ST_NOT_FOUND;
      else waiting_threads.delete(pos);
    end
    // Query and the unused code leave the queue alone.
    if (waiting_threads.size() == 0) begin
      rep.empty = 1'b1;
    end else begin
      rep.thread = waiting_threads[0].thread;
      rep.prio   = waiting_threads[0].prio;
    end
    return rep;
  endfunction

  // Queues a word for the sender and keeps a rough list of the threads that
  // should be waiting, so that random removes mostly name a real thread.
  function automatic void add_word(logic [1:0] op, logic [THREAD_W-1:0] tid,
                                   logic [PRIO_W-1:0] prio);
    request_t req;
    int       k;
    req.drain = 1'b0;
    req.op    = op;
    req.tid   = tid;
    req.prio  = prio;
    words_to_send.push_back(req);
    if (op == OP_INSERT && planned_ids.size() < QUEUE_DEPTH) begin
      planned_ids.push_back(tid);
    end else if (op == OP_REMOVE) begin
      for (k = 0; k < planned_ids.size(); k++) begin
        if (planned_ids[k] == tid) begin
          planned_ids.delete(k);
          break;
        end
      end
    end
  endfunction

  // Stimulus, reset and the end of the run.
  initial begin
    request_t            pause_mark;
    int                  n;
    int                  lean;
    int                  roll;
    logic [THREAD_W-1:0] tid;
    logic [PRIO_W-1:0]   prio;

    // Directed opening: empty queue, ties, a duplicate, the unused code, a
    // miss, then filling the queue to the brim and knocking on it once more.
    add_word(OP_QUERY,  6'd0,  8'd0);
    add_word(OP_REMOVE, 6'd63, 8'd0);    // nothing there yet
    add_word(OP_INSERT, 6'd0,  8'd255);
    add_word(OP_INSERT, 6'd63, 8'd0);    // becomes the new head
    add_word(OP_INSERT, 6'd5,  8'd0);    // equal priority, queues behind
    add_word(OP_INSERT, 6'd63, 8'd128);  // the same thread a second time
    add_word(OP_REMOVE, 6'd63, 8'd0);    // takes the head copy only
    add_word(OP_UNUSED, 6'd21, 8'd170);
    add_word(OP_REMOVE, 6'd42, 8'd0);    // absent thread
    for (n = 0; n < 13; n++) add_word(OP_INSERT, 6'(10 + n), 8'(n * 19));
    add_word(OP_INSERT, 6'd63, 8'd255);  // queue is full now
    add_word(OP_REMOVE, 6'd5,  8'd0);    // head leaves
    add_word(OP_REMOVE, 6'd0,  8'd255);  // tail leaves

    // Random part, in stretches that lean towards filling, draining or a mix
    // so that the queue keeps travelling between empty and full.
    lean = 2;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 30 == 0) lean = $urandom_range(0, 2);
      if (n == RANDOM_WORDS / 2) begin
        pause_mark = '0;
        pause_mark.drain = 1'b1;
        words_to_send.push_back(pause_mark);
      end
      roll = $urandom_range(0, 99);
      prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 3) * 85);
      if (roll < 10) begin
        add_word(($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_QUERY,
                 6'($urandom_range(0, 63)), prio);
      end else if ((lean == 0 && roll < 75) || (lean == 1 && roll < 30) ||
                   (lean == 2 && roll < 55)) begin
        if (planned_ids.size() > 0 && $urandom_range(0, 99) < 10)
          tid = planned_ids[$urandom_range(0, planned_ids.size() - 1)];
        else
          tid = 6'($urandom_range(0, 63));
        add_word(OP_INSERT, tid, prio);
      end else begin
        if (planned_ids.size() > 0 && $urandom_range(0, 99) < 85)
          tid = planned_ids[$urandom_range(0, planned_ids.size() - 1)];
        else
          tid = 6'($urandom_range(0, 63));
        add_word(OP_REMOVE, tid, prio);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Checked at the rising edge, where the sender never touches its queue
    // or s_tvalid, so the last word cannot slip past unseen.
    while (words_to_send.size() != 0 || s_tvalid || head_reports_due.size() != 0)
      @(posedge clk);
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("** priority_wait_queue_unit: PASSED **");
    end else begin
      $display("** priority_wait_queue_unit: FAILED **");
    end
    $finish;
  end

  // Sender: offers words in bursts of random length with random gaps, and
  // holds a word steady until the unit has taken it.
  always @(negedge clk) begin
    request_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took_word) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (words_to_send.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (words_to_send[0].drain) begin
        // Pause until the unit has answered everything it has been given.
        s_tvalid <= 1'b0;
        if (head_reports_due.size() == 0) void'(words_to_send.pop_front());
      end else begin
        req = words_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {2'b00, req.prio, req.tid};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: switches between stall patterns of its own, and once holds off
  // for a long stretch so that the unit backs up and stops taking words.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && reports_checked >= 120) begin
      m_tready       <= 1'b0;
      hold_left      <= 300;
      long_hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(10, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= (cycle_count % 7 < 4);
      endcase
    end
  end

  // Monitor: checks each returned word against the oldest report due, then
  // predicts the report for any word accepted at the same edge. A result
  // always belongs to an earlier word, so the check comes first.
  always @(posedge clk) begin
    head_report_t want;
    request_t     seen;
    if (rst) begin
      took_word <= 1'b0;
    end else begin
      took_word <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (head_reports_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result word, tuser %h tdata %h", $time, m_tuser, m_tdata);
        end else begin
          want = head_reports_due.pop_front();
          reports_checked++;
          if (m_tuser[1:0] != want.status) begin
            error_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, m_tuser[1:0]);
          end
          if (m_tuser[2] != want.empty) begin
            error_count++;
            $display("%0t: queue_empty mismatch, expected %0d, actual %0d",
                     $time, want.empty, m_tuser[2]);
          end
          if (m_tdata[5:0] != want.thread) begin
            error_count++;
            $display("%0t: head_thread mismatch, expected %0d, actual %0d",
                     $time, want.thread, m_tdata[5:0]);
          end
          if (m_tdata[13:6] != want.prio) begin
            error_count++;
            $display("%0t: head_priority mismatch, expected %0d, actual %0d",
                     $time, want.prio, m_tdata[13:6]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        seen.drain = 1'b0;
        seen.op    = s_tuser;
        seen.tid   = s_tdata[5:0];
        seen.prio  = s_tdata[13:6];
        head_reports_due.push_back(apply_to_wait_list(seen));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** priority_wait_queue_unit: FAILED **");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/pwq_pkg.sv
rtl/core/pwq_cell.sv
rtl/core/priority_wait_queue_unit.sv
rtl/core/pwq_checker.sv
verif/priority_wait_queue_unit_tb.sv
